// ===== sv/kwl_pkg.sv =====
`timescale 1ns / 1ps

package kwl_pkg;

   // field widths
   localparam int unsigned KIND_BITS        = 6;
   localparam int unsigned OP_BITS          = 4;
   localparam int unsigned NUM_BITS         = 31;
   localparam int unsigned TEXT_BITS        = 16;
   localparam int unsigned ERR_BITS         = 2;
   localparam int unsigned POS_BITS_DEFAULT = 16;

   // run queue between lexer and output side
   localparam int unsigned RUN_SLOTS  = 3;
   localparam int unsigned RUN_DEPTH  = 4;
   localparam int unsigned SLOT_BITS  = $clog2(RUN_SLOTS + 1);
   localparam int unsigned PTR_BITS   = $clog2(RUN_DEPTH);
   localparam int unsigned LEVEL_BITS = $clog2(RUN_DEPTH + 1);

   localparam logic [NUM_BITS-1:0] NUM_MAX = '1;

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_EOF      = 6'd0;
   localparam logic [KIND_BITS-1:0] KIND_IDENT    = 6'd1;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 6'd2;
   localparam logic [KIND_BITS-1:0] KIND_STRING   = 6'd3;
   localparam logic [KIND_BITS-1:0] KIND_OP       = 6'd4;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN   = 6'd5;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 6'd6;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 6'd7;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 6'd8;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 6'd9;
   localparam logic [KIND_BITS-1:0] KIND_LBRACKET = 6'd10;
   localparam logic [KIND_BITS-1:0] KIND_RBRACKET = 6'd11;
   localparam logic [KIND_BITS-1:0] KIND_COMMA    = 6'd12;
   localparam logic [KIND_BITS-1:0] KIND_COLON    = 6'd13;
   localparam logic [KIND_BITS-1:0] KIND_DOT      = 6'd14;
   localparam logic [KIND_BITS-1:0] KIND_DOTDOT   = 6'd15;
   localparam logic [KIND_BITS-1:0] KIND_KEYWORD0 = 6'd16;
   localparam logic [KIND_BITS-1:0] KIND_ERROR    = 6'd39;

   // operator codes
   localparam logic [OP_BITS-1:0] OP_ADD = 4'd0;
   localparam logic [OP_BITS-1:0] OP_SUB = 4'd1;
   localparam logic [OP_BITS-1:0] OP_MUL = 4'd2;
   localparam logic [OP_BITS-1:0] OP_DIV = 4'd3;
   localparam logic [OP_BITS-1:0] OP_EQ  = 4'd4;
   localparam logic [OP_BITS-1:0] OP_LT  = 4'd5;
   localparam logic [OP_BITS-1:0] OP_LE  = 4'd6;
   localparam logic [OP_BITS-1:0] OP_GT  = 4'd7;
   localparam logic [OP_BITS-1:0] OP_GE  = 4'd8;
   localparam logic [OP_BITS-1:0] OP_NONE = 4'd0;

   // error codes
   localparam logic [ERR_BITS-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_BITS-1:0] ERR_CHAR     = 2'd1;
   localparam logic [ERR_BITS-1:0] ERR_OVERFLOW = 2'd2;

   // source characters with a meaning of their own
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_LESS      = 8'h3C;
   localparam logic [7:0] CH_GREATER   = 8'h3E;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_UNDERLINE = 8'h5F;

   // keyword table, text right-justified in each entry
   localparam int unsigned KW_COUNT   = 23;
   localparam int unsigned KW_MAX_LEN = 9;

   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      "Let", "If", "Else", "End", "For", "While", "Func", "Return", "Match",
      "Case", "Print", "Input", "Class", "Module", "Import", "Macro", "Future",
      "Parallel", "Try", "Catch", "Assert", "Defer", "Interface"
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd2, 4'd4, 4'd3, 4'd3, 4'd5, 4'd4, 4'd6, 4'd5,
      4'd4, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd5, 4'd6,
      4'd8, 4'd3, 4'd5, 4'd6, 4'd5, 4'd9
   };

   typedef enum logic [3:0] {
      LM_IDLE,
      LM_IDENT,
      LM_NUMBER,
      LM_STRING,
      LM_EQ,
      LM_LT,
      LM_GT,
      LM_DOT,
      LM_ERROR
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [OP_BITS-1:0]   op_code;
      logic [NUM_BITS-1:0]  number_value;
      logic [TEXT_BITS-1:0] text_start;
      logic [TEXT_BITS-1:0] text_length;
      logic [ERR_BITS-1:0]  error_code;
      logic                 last_of_run;
   } rsp_type;

   // all results caused by one source byte
   typedef struct packed {
      logic [SLOT_BITS-1:0]          count;
      rsp_type [RUN_SLOTS-1:0]       tok;
   } run_type;

   function automatic logic [7:0] kw_char(int unsigned k, logic [3:0] i);
      logic [8*KW_MAX_LEN-1:0] text;
      logic [3:0]              len;
      text = KW_TEXT[k];
      len  = KW_LEN[k];
      if (i < len) begin
         return text[8*(len - 4'd1 - i) +: 8];
      end
      return CH_NUL;
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_ident_char(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDERLINE);
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

endpackage

// ===== sv/kwl_front.sv =====
`timescale 1ns / 1ps

module kwl_front import kwl_pkg::*; #(
   parameter int unsigned POSITION_BITS = POS_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req_data,
   output logic    run_write,
   output run_type run_data
);

   typedef logic [POSITION_BITS-1:0] pos_type;

   localparam pos_type POS_MAX = '1;

   typedef struct packed {
      lex_mode_type          mode;
      logic [KW_COUNT-1:0]   cand;
      logic [NUM_BITS-1:0]   accum;
      logic                  ovf;
      pos_type               start;
      pos_type               count;
   } lex_state_type;

   typedef struct packed {
      logic         valid;
      rsp_type      tok;
      lex_mode_type mode;
   } flush_type;

   localparam lex_state_type ST_RESET = '{
      mode: LM_IDLE, cand: '1, accum: '0, ovf: 1'b0, start: '0, count: '0
   };

   lex_state_type st_ff, st_in;
   pos_type       pos_ff, pos_in;

   function automatic rsp_type make_tok(logic [KIND_BITS-1:0] kind,
                                        logic [OP_BITS-1:0] op,
                                        logic [NUM_BITS-1:0] value,
                                        pos_type at, pos_type len,
                                        logic [ERR_BITS-1:0] err);
      rsp_type t;
      t.kind         = kind;
      t.op_code      = op;
      t.number_value = value;
      t.text_start   = TEXT_BITS'(at);
      t.text_length  = TEXT_BITS'(len);
      t.error_code   = err;
      t.last_of_run  = 1'b0;
      return t;
   endfunction

   function automatic pos_type count_up(pos_type n);
      return (n == POS_MAX) ? n : n + 1'b1;
   endfunction

   // narrow the keyword mask by one more character
   function automatic lex_state_type ident_add(lex_state_type s, logic [7:0] c);
      lex_state_type r;
      r = s;
      for (int unsigned k = 0; k < KW_COUNT; k++) begin
         if (s.count >= pos_type'(KW_MAX_LEN) || kw_char(k, s.count[3:0]) != c) begin
            r.cand[k] = 1'b0;
         end
      end
      r.count = count_up(s.count);
      return r;
   endfunction

   // accum * 10 + digit, as shifts and adds
   function automatic lex_state_type number_add(lex_state_type s, logic [7:0] c);
      lex_state_type         r;
      logic [NUM_BITS+3:0]   v;
      r = s;
      v = ({4'b0, s.accum} << 3) + ({4'b0, s.accum} << 1) + (NUM_BITS+4)'(c[3:0]);
      if (v > (NUM_BITS+4)'(NUM_MAX)) begin
         r.ovf = 1'b1;
      end else if (!s.ovf) begin
         r.accum = v[NUM_BITS-1:0];
      end
      r.count = count_up(s.count);
      return r;
   endfunction

   function automatic flush_type lex_flush(lex_state_type s);
      flush_type             f;
      logic [KIND_BITS-1:0]  kind;
      f.valid = 1'b0;
      f.tok   = '0;
      f.mode  = LM_IDLE;
      kind    = KIND_IDENT;
      for (int unsigned k = 0; k < KW_COUNT; k++) begin
         if (s.cand[k] && s.count == pos_type'(KW_LEN[k])) begin
            kind = KIND_KEYWORD0 + KIND_BITS'(k);
         end
      end
      case (s.mode)
         LM_IDENT: begin
            f.valid = 1'b1;
            f.tok   = make_tok(kind, OP_NONE, '0, s.start, s.count, ERR_NONE);
         end
         LM_NUMBER: begin
            f.valid = 1'b1;
            if (s.ovf) begin
               f.tok  = make_tok(KIND_ERROR, OP_NONE, '0, s.start, s.count, ERR_OVERFLOW);
               f.mode = LM_ERROR;
            end else begin
               f.tok = make_tok(KIND_NUMBER, OP_NONE, s.accum, s.start, s.count, ERR_NONE);
            end
         end
         LM_STRING: begin
            f.valid = 1'b1;
            f.tok   = make_tok(KIND_STRING, OP_NONE, '0, s.start, s.count, ERR_NONE);
         end
         LM_EQ: begin
            f.valid = 1'b1;
            f.tok   = make_tok(KIND_ASSIGN, OP_NONE, '0, s.start, pos_type'(1), ERR_NONE);
         end
         LM_LT: begin
            f.valid = 1'b1;
            f.tok   = make_tok(KIND_OP, OP_LT, '0, s.start, pos_type'(1), ERR_NONE);
         end
         LM_GT: begin
            f.valid = 1'b1;
            f.tok   = make_tok(KIND_OP, OP_GT, '0, s.start, pos_type'(1), ERR_NONE);
         end
         LM_DOT: begin
            f.valid = 1'b1;
            f.tok   = make_tok(KIND_DOT, OP_NONE, '0, s.start, pos_type'(1), ERR_NONE);
         end
         LM_ERROR: begin
            f.mode = LM_ERROR;
         end
         default: begin
            f.mode = LM_IDLE;
         end
      endcase
      return f;
   endfunction

   logic [7:0]    c;
   logic          last_byte;
   logic          used;
   logic          flush_now;
   lex_state_type s1, s2, s0;
   flush_type     f1, f3;
   logic [3:0]    cv;
   rsp_type [3:0] ct;
   logic [SLOT_BITS-1:0] n;
   run_type       run;

   always_comb begin
      c         = req_data.ch;
      last_byte = req_data.end_of_source || (c == CH_NUL);
      used      = 1'b0;
      flush_now = 1'b0;
      cv        = '0;
      ct        = '0;
      s1        = st_ff;
      f1        = lex_flush(st_ff);

      // continue or close the pending token
      case (st_ff.mode)
         LM_IDENT: begin
            if (is_ident_char(c)) begin
               s1   = ident_add(st_ff, c);
               used = 1'b1;
            end else begin
               flush_now = 1'b1;
            end
         end
         LM_NUMBER: begin
            if (is_digit(c)) begin
               s1   = number_add(st_ff, c);
               used = 1'b1;
            end else begin
               flush_now = 1'b1;
            end
         end
         LM_STRING: begin
            if (c == CH_QUOTE) begin
               flush_now = 1'b1;
               used      = 1'b1;
            end else if (c == CH_NUL) begin
               flush_now = 1'b1;
            end else begin
               s1.count = count_up(st_ff.count);
               used     = 1'b1;
            end
         end
         LM_EQ, LM_LT, LM_GT: begin
            if (c == CH_EQUAL) begin
               cv[0] = 1'b1;
               if (st_ff.mode == LM_EQ) begin
                  ct[0] = make_tok(KIND_OP, OP_EQ, '0, st_ff.start, pos_type'(2), ERR_NONE);
               end else if (st_ff.mode == LM_LT) begin
                  ct[0] = make_tok(KIND_OP, OP_LE, '0, st_ff.start, pos_type'(2), ERR_NONE);
               end else begin
                  ct[0] = make_tok(KIND_OP, OP_GE, '0, st_ff.start, pos_type'(2), ERR_NONE);
               end
               s1.mode = LM_IDLE;
               used    = 1'b1;
            end else begin
               flush_now = 1'b1;
            end
         end
         LM_DOT: begin
            if (c == CH_DOT) begin
               cv[0]   = 1'b1;
               ct[0]   = make_tok(KIND_DOTDOT, OP_NONE, '0, st_ff.start, pos_type'(2),
                                  ERR_NONE);
               s1.mode = LM_IDLE;
               used    = 1'b1;
            end else begin
               flush_now = 1'b1;
            end
         end
         LM_ERROR: begin
            used = 1'b1;
         end
         default: begin
            s1.mode = LM_IDLE;
         end
      endcase
      if (flush_now) begin
         cv[0]   = f1.valid;
         ct[0]   = f1.tok;
         s1.mode = f1.mode;
      end

      // classify the byte when nothing is pending
      s2       = s1;
      s0       = s1;
      s0.cand  = '1;
      s0.accum = '0;
      s0.ovf   = 1'b0;
      s0.start = pos_ff;
      s0.count = '0;
      if (!used && s1.mode == LM_IDLE && c != CH_NUL && !is_space(c)) begin
         if (is_alpha(c) || c == CH_UNDERLINE) begin
            s2      = ident_add(s0, c);
            s2.mode = LM_IDENT;
         end else if (is_digit(c)) begin
            s2      = number_add(s0, c);
            s2.mode = LM_NUMBER;
         end else begin
            case (c)
               CH_QUOTE: begin
                  s2       = s0;
                  s2.start = pos_ff + 1'b1;
                  s2.mode  = LM_STRING;
               end
               CH_EQUAL, CH_LESS, CH_GREATER, CH_DOT: begin
                  s2       = s0;
                  s2.count = pos_type'(1);
                  if (c == CH_EQUAL) begin
                     s2.mode = LM_EQ;
                  end else if (c == CH_LESS) begin
                     s2.mode = LM_LT;
                  end else if (c == CH_GREATER) begin
                     s2.mode = LM_GT;
                  end else begin
                     s2.mode = LM_DOT;
                  end
               end
               CH_PLUS: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_OP, OP_ADD, '0, pos_ff, pos_type'(1), ERR_NONE);
               end
               CH_MINUS: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_OP, OP_SUB, '0, pos_ff, pos_type'(1), ERR_NONE);
               end
               CH_STAR: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_OP, OP_MUL, '0, pos_ff, pos_type'(1), ERR_NONE);
               end
               CH_SLASH: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_OP, OP_DIV, '0, pos_ff, pos_type'(1), ERR_NONE);
               end
               CH_LPAREN: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_LPAREN, OP_NONE, '0, pos_ff, pos_type'(1), ERR_NONE);
               end
               CH_RPAREN: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_RPAREN, OP_NONE, '0, pos_ff, pos_type'(1), ERR_NONE);
               end
               CH_LBRACE: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_LBRACE, OP_NONE, '0, pos_ff, pos_type'(1), ERR_NONE);
               end
               CH_RBRACE: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_RBRACE, OP_NONE, '0, pos_ff, pos_type'(1), ERR_NONE);
               end
               CH_LBRACKET: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_LBRACKET, OP_NONE, '0, pos_ff, pos_type'(1),
                                   ERR_NONE);
               end
               CH_RBRACKET: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_RBRACKET, OP_NONE, '0, pos_ff, pos_type'(1),
                                   ERR_NONE);
               end
               CH_COMMA: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_COMMA, OP_NONE, '0, pos_ff, pos_type'(1), ERR_NONE);
               end
               CH_COLON: begin
                  cv[1] = 1'b1;
                  ct[1] = make_tok(KIND_COLON, OP_NONE, '0, pos_ff, pos_type'(1), ERR_NONE);
               end
               default: begin
                  cv[1]   = 1'b1;
                  ct[1]   = make_tok(KIND_ERROR, OP_NONE, '0, pos_ff, pos_type'(1), ERR_CHAR);
                  s2.mode = LM_ERROR;
               end
            endcase
         end
      end

      // end of source: close what is pending, then eof, then back to reset state
      f3 = lex_flush(s2);
      if (last_byte) begin
         cv[2]  = f3.valid;
         ct[2]  = f3.tok;
         cv[3]  = 1'b1;
         ct[3]  = make_tok(KIND_EOF, OP_NONE, '0, pos_ff, '0, ERR_NONE);
         st_in  = ST_RESET;
         pos_in = '0;
      end else begin
         st_in  = s2;
         pos_in = pos_ff + 1'b1;
      end
      if (!accept) begin
         st_in  = st_ff;
         pos_in = pos_ff;
      end

      // pack the results of this byte in order
      run = '0;
      n   = '0;
      for (int unsigned i = 0; i < 4; i++) begin
         if (cv[i] && n < SLOT_BITS'(RUN_SLOTS)) begin
            run.tok[n[1:0]] = ct[i];
            n               = n + 1'b1;
         end
      end
      run.count = n;
   end

   assign run_write = accept && (n != '0);
   assign run_data  = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_RESET;
         pos_ff <= '0;
      end else begin
         st_ff  <= st_in;
         pos_ff <= pos_in;
      end
   end

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> st_ff.mode == LM_IDLE && pos_ff == '0)
      else $error("lexer state not cleared after end of source");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      st_ff.mode == LM_ERROR && !(accept && last_byte) |=> st_ff.mode == LM_ERROR)
      else $error("error mode left before end of source");

   a_pos_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(pos_ff) && $stable(st_ff))
      else $error("lexer state moved without a transfer");

   a_end_gives_run: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |-> run_write)
      else $error("end of source gave no eof result");

endmodule

// ===== sv/kwl_back.sv =====
`timescale 1ns / 1ps

module kwl_back import kwl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    run_write,
   input  run_type run_data,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   run_type                 mem_ff [RUN_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_BITS-1:0]   level_ff, level_in;
   logic [1:0]              idx_ff, idx_in;

   run_type head;
   logic    is_last;
   logic    pop_fire;
   logic    run_done;

   assign head     = mem_ff[rd_ptr_ff];
   assign is_last  = (idx_ff == head.count[1:0] - 2'd1);
   assign empty    = (level_ff == '0);
   assign full     = (level_ff == LEVEL_BITS'(RUN_DEPTH));
   assign pop_fire = pop && !empty;
   assign run_done = pop_fire && is_last;

   always_comb begin
      rsp_data             = head.tok[idx_ff];
      rsp_data.last_of_run = is_last;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      idx_in    = idx_ff;
      level_in  = level_ff;
      if (run_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(RUN_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (run_done) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(RUN_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         idx_in    = '0;
      end else if (pop_fire) begin
         idx_in = idx_ff + 1'b1;
      end
      case ({run_write, run_done})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (run_write) begin
         mem_ff[wr_ptr_ff] <= run_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
         idx_ff    <= idx_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      run_write |-> !full)
      else $error("run written into a full queue");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_BITS'(RUN_DEPTH))
      else $error("queue level beyond depth");

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff < head.count[1:0] && head.count != '0)
      else $error("result index outside the head run");

   a_write_shows: assert property (@(posedge clock) disable iff (reset)
      run_write && empty |=> !empty)
      else $error("written run not visible next cycle");

endmodule

// ===== sv/keyword_token_lexer.sv =====
// a transferred byte's results are registered in the run queue, from whose head rsp_data is read
// throughput: one source byte per cycle while full is low; the output side moves one
//   result per cycle while pop is high, so a run of k results (up to three) takes k pops
// a four-entry run queue between the lexer and the output side absorbs stalls on either side
// reset: synchronous, active high; clears lexer state, byte offset and the run queue
`timescale 1ns / 1ps

module keyword_token_lexer import kwl_pkg::*; #(
   parameter int unsigned POSITION_BITS = POS_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   // source bytes
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   // tokens
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   // byte transfer
   logic    accept;
   // one entry per byte that produced tokens
   logic    run_write;
   run_type run_data;

   assign accept = push && !full;

   // lexer: classifies each byte, tracks the pending token, builds the run of results
   kwl_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .run_write (run_write),
      .run_data  (run_data)
   );

   // output side: queues runs and hands out one token per transfer
   kwl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .run_write (run_write),
      .run_data  (run_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
